// ===== rtl/buddy_page_allocator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Shared property wrappers for the port checker; clk and arst_n come from
// the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");

// Next-cycle implication, disabled while reset is asserted
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");

`endif

// ===== rtl/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Status and action codes, register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package bpa_pkg;

	// Default deepest pool order (pool of 2^MAX_ORDER pages)
	localparam int unsigned MAX_ORDER_DEF = 10;

	// Pool order after reset, before saturation
	localparam logic [3:0] POOL_ORDER_RESET = 4'd10;

	// Register index carried in paddr[2]
	localparam logic REG_POOL_ORDER = 1'b0;

	// Action codes
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LOW_FREE = 2'd1,
		ST_NO_FIT   = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	// Configuration handed from the register block to the sequencer
	typedef struct packed {
		logic       rebuild;
		logic [3:0] new_order;
		logic [3:0] pool_order;
	} cfg_t;

	// Clamp a written order to the deepest supported pool
	function automatic logic [3:0] sat_order(input logic [3:0] v, input int unsigned mx);
		return (32'(v) > mx) ? 4'(mx) : v;
	endfunction

endpackage

// ===== rtl/bpa_tree_ram.sv =====
// ----------------------------------------------------------------------------
// Buddy tree memory
// One write port and two registered read ports over the node array.
// ----------------------------------------------------------------------------
module bpa_tree_ram #(
	parameter int unsigned AW = 11,
	parameter int unsigned DW = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	localparam int unsigned DEPTH = (1 << AW) - 1;

	logic [DW-1:0] mem [0:DEPTH-1];

	// Write node
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read both ports through registered outputs
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/bpa_cfg.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator register block
// APB-style access to the pool order; a write requests a tree rebuild.
// ----------------------------------------------------------------------------
module bpa_cfg #(
	parameter int unsigned MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output bpa_pkg::cfg_t cfg
);

	logic       wr;
	logic [3:0] order_q;

	// Decode register write
	assign wr = psel && penable && pwrite && (paddr[2] == bpa_pkg::REG_POOL_ORDER);

	// Hold pool order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= bpa_pkg::sat_order(bpa_pkg::POOL_ORDER_RESET, MAX_ORDER);
		end else if (wr) begin
			order_q <= bpa_pkg::sat_order(pwdata[3:0], MAX_ORDER);
		end
	end

	assign prdata = (paddr[2] == bpa_pkg::REG_POOL_ORDER) ? {28'd0, order_q} : 32'd0;

	assign cfg.rebuild    = wr;
	assign cfg.new_order  = bpa_pkg::sat_order(pwdata[3:0], MAX_ORDER);
	assign cfg.pool_order = order_q;

endmodule

// ===== rtl/bpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator sequencer
// Rebuild sweep, tree walks for allocate and free, and the result register.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
	parameter int unsigned MAX_ORDER = bpa_pkg::MAX_ORDER_DEF,
	localparam int unsigned IW = MAX_ORDER + 1,
	localparam int unsigned VW = MAX_ORDER + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bpa_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [10:0]          request_pages,
	input  logic [9:0]           page_offset,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [9:0]           block_offset,
	output logic [10:0]          block_pages,
	output logic [10:0]          avail_pages,
	output logic                 mem_we,
	output logic [IW-1:0]        mem_waddr,
	output logic [VW-1:0]        mem_wdata,
	output logic [IW-1:0]        mem_raddr_a,
	output logic [IW-1:0]        mem_raddr_b,
	input  logic [VW-1:0]        mem_rdata_a,
	input  logic [VW-1:0]        mem_rdata_b
);

	// Common width for compares against requests and offsets
	localparam int unsigned RW = (VW > 12) ? VW : 12;
	localparam logic [3:0] RST_ORDER = bpa_pkg::sat_order(bpa_pkg::POOL_ORDER_RESET, MAX_ORDER);

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_INIT   = 13'b0000000000010,
		S_START  = 13'b0000000000100,
		S_ROUND  = 13'b0000000001000,
		S_ROOT   = 13'b0000000010000,
		S_DN_RD  = 13'b0000000100000,
		S_DN_CHK = 13'b0000001000000,
		S_MARK   = 13'b0000010000000,
		S_FC_RD  = 13'b0000100000000,
		S_FC_CHK = 13'b0001000000000,
		S_UP_RD  = 13'b0010000000000,
		S_UP_WR  = 13'b0100000000000,
		S_DONE   = 13'b1000000000000
	} state_t;

	state_t           state_q;
	logic [IW-1:0]    sweep_q;
	logic [VW-1:0]    sweep_val_q;
	logic [VW-1:0]    free_q;
	logic             out_valid_q;

	logic             act_q;
	logic [10:0]      req_q;
	logic [9:0]       poff_q;
	logic [IW-1:0]    idx_q;
	logic [VW-1:0]    ns_q;
	logic [IW-1:0]    off_q;
	logic [RW-1:0]    rounded_q;
	bpa_pkg::status_t res_status_q;
	logic [IW-1:0]    res_off_q;
	logic [RW-1:0]    res_pages_q;
	bpa_pkg::status_t out_status_q;
	logic [9:0]       out_off_q;
	logic [10:0]      out_pages_q;
	logic [10:0]      out_free_q;

	logic [VW-1:0]    size;
	logic [VW-1:0]    new_size;
	logic [IW:0]      sweep_next2;
	logic             sweep_pow2;
	logic             sweep_last;
	logic [10:0]      want;
	logic [IW-1:0]    left;
	logic [IW-1:0]    parent;
	logic [IW-1:0]    up_left;
	logic [VW:0]      pair_sum;
	logic [VW-1:0]    pair_max;
	logic [VW-1:0]    merged;
	logic             out_load;

	assign size     = VW'(1) << cfg.pool_order;
	assign new_size = VW'(1) << cfg.new_order;

	// Sweep bookkeeping: next node number is sweep + 2 in one-based terms
	assign sweep_next2 = {1'b0, sweep_q} + (IW+1)'(2);
	assign sweep_pow2  = (sweep_next2 & (sweep_next2 - (IW+1)'(1))) == '0;
	assign sweep_last  = {1'b0, sweep_q} == ({size, 1'b0} - (IW+1)'(2));

	assign want     = (req_q == 11'd0) ? 11'd1 : req_q;
	assign left     = {idx_q[IW-2:0], 1'b1};
	assign parent   = (idx_q - IW'(1)) >> 1;
	assign up_left  = {parent[IW-2:0], 1'b1};
	assign pair_sum = {1'b0, mem_rdata_a} + {1'b0, mem_rdata_b};
	assign pair_max = (mem_rdata_a >= mem_rdata_b) ? mem_rdata_a : mem_rdata_b;
	assign merged   = ((act_q == bpa_pkg::ACT_FREE) && (pair_sum == {1'b0, ns_q})) ?
		ns_q : pair_max;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Drive memory ports per state
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = '0;
		mem_raddr_a = '0;
		mem_raddr_b = '0;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
				mem_wdata = sweep_val_q;
			end
			S_DN_RD: begin
				mem_raddr_a = left;
			end
			S_MARK: begin
				mem_we = 1'b1;
			end
			S_FC_RD: begin
				mem_raddr_a = idx_q;
			end
			S_FC_CHK: begin
				mem_we    = (mem_rdata_a == '0);
				mem_wdata = ns_q;
			end
			S_UP_RD: begin
				mem_raddr_a = up_left;
				mem_raddr_b = up_left + IW'(1);
			end
			S_UP_WR: begin
				mem_we    = 1'b1;
				mem_wdata = merged;
			end
			default: begin
			end
		endcase
	end

	// Advance sequencer, sweep and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			sweep_val_q <= VW'(1) << RST_ORDER;
			free_q      <= VW'(1) << RST_ORDER;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.rebuild) begin
				state_q     <= S_INIT;
				sweep_q     <= '0;
				sweep_val_q <= new_size;
				free_q      <= new_size;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_valid) begin
							state_q <= S_START;
						end
					end
					S_INIT: begin
						sweep_q <= sweep_q + IW'(1);
						if (sweep_pow2) begin
							sweep_val_q <= sweep_val_q >> 1;
						end
						if (sweep_last) begin
							state_q <= S_IDLE;
						end
					end
					S_START: begin
						if (act_q == bpa_pkg::ACT_ALLOC) begin
							state_q <= (RW'(want) > RW'(free_q)) ? S_DONE : S_ROUND;
						end else begin
							state_q <= (RW'(poff_q) >= RW'(size)) ? S_DONE : S_FC_RD;
						end
					end
					S_ROUND: begin
						if (rounded_q >= RW'(want)) begin
							state_q <= S_ROOT;
						end
					end
					S_ROOT: begin
						state_q <= (RW'(mem_rdata_a) < rounded_q) ? S_DONE : S_DN_RD;
					end
					S_DN_RD: begin
						state_q <= (RW'(ns_q) == rounded_q) ? S_MARK : S_DN_CHK;
					end
					S_DN_CHK: begin
						state_q <= S_DN_RD;
					end
					S_MARK: begin
						free_q  <= free_q - VW'(rounded_q);
						state_q <= (idx_q == '0) ? S_DONE : S_UP_RD;
					end
					S_FC_RD: begin
						state_q <= S_FC_CHK;
					end
					S_FC_CHK: begin
						if (mem_rdata_a != '0) begin
							state_q <= (idx_q == '0) ? S_DONE : S_FC_RD;
						end else begin
							free_q  <= free_q + ns_q;
							state_q <= (idx_q == '0) ? S_DONE : S_UP_RD;
						end
					end
					S_UP_RD: begin
						state_q <= S_UP_WR;
					end
					S_UP_WR: begin
						state_q <= (idx_q == '0) ? S_DONE : S_UP_RD;
					end
					S_DONE: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	// Track walk position, block size, offset and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q  <= action;
				req_q  <= request_pages;
				poff_q <= page_offset;
			end
			S_START: begin
				rounded_q    <= RW'(1);
				res_off_q    <= '0;
				res_pages_q  <= '0;
				ns_q         <= VW'(1);
				idx_q        <= IW'(RW'(poff_q) + RW'(size) - RW'(1));
				if (act_q == bpa_pkg::ACT_ALLOC) begin
					res_status_q <= bpa_pkg::ST_LOW_FREE;
				end else begin
					res_status_q <= bpa_pkg::ST_BAD_FREE;
				end
			end
			S_ROUND: begin
				if (rounded_q < RW'(want)) begin
					rounded_q <= rounded_q << 1;
				end
			end
			S_ROOT: begin
				res_status_q <= bpa_pkg::ST_NO_FIT;
				ns_q         <= size;
				idx_q        <= '0;
				off_q        <= '0;
			end
			S_DN_CHK: begin
				ns_q <= ns_q >> 1;
				if (RW'(mem_rdata_a) >= rounded_q) begin
					idx_q <= left;
				end else begin
					idx_q <= left + IW'(1);
					off_q <= off_q + IW'(ns_q >> 1);
				end
			end
			S_MARK: begin
				res_status_q <= bpa_pkg::ST_OK;
				res_off_q    <= off_q;
				res_pages_q  <= rounded_q;
			end
			S_FC_CHK: begin
				if (mem_rdata_a != '0) begin
					ns_q  <= ns_q << 1;
					idx_q <= parent;
				end else begin
					res_status_q <= bpa_pkg::ST_OK;
					res_pages_q  <= RW'(ns_q);
				end
			end
			S_UP_RD: begin
				idx_q <= parent;
				if (act_q == bpa_pkg::ACT_FREE) begin
					ns_q <= ns_q << 1;
				end
			end
			default: begin
			end
		endcase
		// Capture the result together with the free count it leaves behind
		if (out_load) begin
			out_status_q <= res_status_q;
			out_off_q    <= RW'(res_off_q) >> 0 == '0 ? 10'd0 : 10'(RW'(res_off_q));
			out_pages_q  <= 11'(res_pages_q);
			out_free_q   <= 11'(free_q);
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign block_offset = out_off_q;
	assign block_pages  = out_pages_q;
	assign avail_pages  = out_free_q;

endmodule

// ===== rtl/buddy_page_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator
// Binary-tree buddy allocator over a pool of 2^pool_order pages.
// ----------------------------------------------------------------------------
// One request at a time. An allocate rounds the request to a power of two by
// doubling, walks down from the root to a free node of that size and then
// refreshes the nodes on the way back up; a free climbs from the leaf to the
// marked node and then refreshes the nodes on the way back up. Every level
// costs a registered read of the tree memory and, on the way up, a write of
// the refreshed node. After reset and after every pool_order write a rebuild
// pass writes all 2^(pool_order+1)-1 nodes of the tree while in_stall stays
// high; register accesses are taken throughout. A result waits in an output
// register, so the next request is taken while it is still stalled.
module buddy_page_allocator_top #(
	parameter int unsigned MAX_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [10:0] request_pages,
	input  logic [9:0]  page_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  block_offset,
	output logic [10:0] block_pages,
	output logic [10:0] avail_pages
);

	localparam int unsigned IW = MAX_ORDER + 1;
	localparam int unsigned VW = MAX_ORDER + 1;

	bpa_pkg::cfg_t cfg;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [VW-1:0] mem_wdata;
	logic [IW-1:0] mem_raddr_a;
	logic [IW-1:0] mem_raddr_b;
	logic [VW-1:0] mem_rdata_a;
	logic [VW-1:0] mem_rdata_b;

	assign pready = 1'b1;

	bpa_cfg #(
		.MAX_ORDER(MAX_ORDER)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bpa_tree_ram #(
		.AW(IW),
		.DW(VW)
	) u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (mem_rdata_a),
		.rdata_b (mem_rdata_b)
	);

	bpa_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.request_pages (request_pages),
		.page_offset   (page_offset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.block_offset  (block_offset),
		.block_pages   (block_pages),
		.avail_pages   (avail_pages),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr_a   (mem_raddr_a),
		.mem_raddr_b   (mem_raddr_b),
		.mem_rdata_a   (mem_rdata_a),
		.mem_rdata_b   (mem_rdata_b)
	);

endmodule

// ===== rtl/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy allocator port checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_top_macros.svh"

module bpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [9:0]  block_offset,
	input logic [10:0] block_pages
);

	// A waiting result stays offered
	`BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// An accepted request raises in_stall once it has been taken
	`BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// A failed request reports no block
	`BPA_ASSERT_NOW(a_fail_empty, out_valid && (status != bpa_pkg::ST_OK),
		(block_pages == 11'd0) && (block_offset == 10'd0))

	// A pool order write starts a rebuild that holds off requests
	`BPA_ASSERT_NEXT(a_rebuild_stall,
		psel && penable && pwrite && (paddr[2] == bpa_pkg::REG_POOL_ORDER), in_stall)

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
